// ===== hdl/gsa_pkg.sv =====
// ----------------------------------------------------------------------------
// gsa_pkg
// Shared types and constants of the generational slot allocator.
// ----------------------------------------------------------------------------
package gsa_pkg;

  localparam int unsigned SlotsDef   = 1024;
  localparam int unsigned GenBitsDef = 8;

  localparam int unsigned ModeW  = 2;
  localparam int unsigned HIdxW  = 12;
  localparam int unsigned HGenW  = 8;
  localparam int unsigned OIdxW  = 11;
  localparam int unsigned OGenW  = 8;
  localparam int unsigned LiveW  = 11;

  typedef enum logic [ModeW-1:0] {
    OP_ALLOC = 2'd0,
    OP_FREE  = 2'd1,
    OP_CHECK = 2'd2,
    OP_NOP   = 2'd3
  } op_e;

  typedef struct packed {
    logic [ModeW-1:0] mode;
    logic [HIdxW-1:0] handle_index;
    logic [HGenW-1:0] handle_generation;
  } req_t;

  typedef struct packed {
    logic             ok;
    logic [OIdxW-1:0] out_index;
    logic [OGenW-1:0] out_generation;
    logic [LiveW-1:0] live_count;
  } rsp_t;

  // Classified request handed from front to back.
  typedef struct packed {
    op_e              op;
    logic             hit;
    logic [HIdxW-1:0] slot;
    logic [HGenW-1:0] gen;
  } cls_t;

endpackage

// ===== hdl/gsa_front.sv =====
// ----------------------------------------------------------------------------
// gsa_front
// Decodes requests, range-checks the handle index and queues the result.
// ----------------------------------------------------------------------------
module gsa_front #(
  parameter int unsigned SLOTS = gsa_pkg::SlotsDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  gsa_pkg::req_t in_data_i,
  output logic          q_valid_o,
  input  logic          q_pop_i,
  output gsa_pkg::cls_t q_item_o
);
  import gsa_pkg::*;

  cls_t       cls;
  cls_t       slot_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       push;

  always_comb begin
    case (in_data_i.mode)
      OP_ALLOC: cls.op = OP_ALLOC;
      OP_FREE:  cls.op = OP_FREE;
      OP_CHECK: cls.op = OP_CHECK;
      default:  cls.op = OP_NOP;
    endcase
    cls.hit  = (in_data_i.handle_index != '0) &&
               (in_data_i.handle_index <= HIdxW'(SLOTS));
    cls.slot = in_data_i.handle_index - HIdxW'(1);
    cls.gen  = in_data_i.handle_generation;
  end

  assign in_ready_o = (cnt_q != 2'd2);
  assign push       = in_valid_i && in_ready_o;
  assign q_valid_o  = (cnt_q != 2'd0);
  assign q_item_o   = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = q_pop_i ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + 2'(push) - 2'(q_pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= cls;
    end
  end

endmodule

// ===== hdl/gsa_back.sv =====
// ----------------------------------------------------------------------------
// gsa_back
// Slot memory, free-list head and fill mark; read, then evaluate and write.
// ----------------------------------------------------------------------------
module gsa_back #(
  parameter int unsigned SLOTS    = gsa_pkg::SlotsDef,
  parameter int unsigned GEN_BITS = gsa_pkg::GenBitsDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          q_valid_i,
  output logic          q_pop_o,
  input  gsa_pkg::cls_t q_item_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output gsa_pkg::rsp_t out_data_o
);
  import gsa_pkg::*;

  localparam int unsigned AddrW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned LinkW = $clog2(SLOTS + 1);
  localparam int unsigned WordW = 1 + GEN_BITS + LinkW;
  localparam int unsigned CmpW  = (GEN_BITS > HGenW) ? GEN_BITS : HGenW;

  typedef enum logic [1:0] {
    ST_READ = 2'b01,
    ST_EXEC = 2'b10
  } state_e;

  state_e state_q, state_d;

  logic [WordW-1:0] mem [SLOTS];
  logic [WordW-1:0] rd_word_q;
  logic [WordW-1:0] wr_word;
  logic             rd_en;
  logic             mem_we;
  logic [AddrW-1:0] rd_addr;

  cls_t             cur_q;
  logic [AddrW-1:0] cur_addr_q;
  logic [LinkW-1:0] head_q, head_d;
  logic [LinkW-1:0] bump_q, bump_d;
  logic [LinkW-1:0] total_q, total_d;
  logic             out_valid_q;
  rsp_t             out_q, rsp;

  logic                untouched;
  logic                eff_active;
  logic [GEN_BITS-1:0] eff_gen;
  logic [LinkW-1:0]    eff_link;
  logic [LinkW-1:0]    cur_link;
  logic                pool_empty;
  logic                live;
  logic                exec_fire;

  assign pool_empty = (head_q == LinkW'(SLOTS));

  // issue
  always_comb begin
    q_pop_o = (state_q == ST_READ) && q_valid_i;
    rd_addr = (q_item_i.op == OP_ALLOC) ? head_q[AddrW-1:0] : q_item_i.slot[AddrW-1:0];
    rd_en   = q_pop_o && ((q_item_i.op == OP_ALLOC) ? !pool_empty : q_item_i.hit);
  end

  // slots at or above the fill mark are treated as holding their reset contents
  always_comb begin
    cur_link   = LinkW'(cur_addr_q);
    untouched  = (cur_link >= bump_q);
    eff_active = untouched ? 1'b0 : rd_word_q[WordW-1];
    eff_gen    = untouched ? '0 : rd_word_q[LinkW +: GEN_BITS];
    eff_link   = untouched ? (cur_link + LinkW'(1)) : rd_word_q[LinkW-1:0];
    live       = cur_q.hit && eff_active && (CmpW'(eff_gen) == CmpW'(cur_q.gen));
  end

  assign exec_fire = (state_q == ST_EXEC) && (!out_valid_q || out_ready_i);

  always_comb begin
    head_d  = head_q;
    bump_d  = bump_q;
    total_d = total_q;
    mem_we  = 1'b0;
    wr_word = {1'b1, eff_gen, eff_link};
    rsp     = '0;
    case (cur_q.op)
      OP_ALLOC: begin
        if (!pool_empty) begin
          mem_we             = exec_fire;
          head_d             = eff_link;
          bump_d             = untouched ? bump_q + LinkW'(1) : bump_q;
          total_d            = total_q + LinkW'(1);
          rsp.ok             = 1'b1;
          rsp.out_index      = OIdxW'(cur_link + LinkW'(1));
          rsp.out_generation = OGenW'(eff_gen);
        end
      end
      OP_FREE: begin
        if (live) begin
          mem_we  = exec_fire;
          wr_word = {1'b0, eff_gen + GEN_BITS'(1), head_q};
          head_d  = cur_link;
          total_d = (total_q != '0) ? total_q - LinkW'(1) : total_q;
          rsp.ok  = 1'b1;
        end
      end
      OP_CHECK: begin
        rsp.ok = live;
      end
      default: begin
        rsp.ok = 1'b0;
      end
    endcase
    rsp.live_count = LiveW'(total_d);
  end

  always_comb begin
    case (state_q)
      ST_READ: state_d = q_pop_o ? ST_EXEC : ST_READ;
      ST_EXEC: state_d = exec_fire ? ST_READ : ST_EXEC;
      default: state_d = ST_READ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[cur_addr_q] <= wr_word;
    end
    if (rd_en) begin
      rd_word_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      cur_q      <= q_item_i;
      cur_addr_q <= rd_addr;
    end
    if (exec_fire) begin
      out_q <= rsp;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_READ;
      head_q      <= '0;
      bump_q      <= '0;
      total_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (exec_fire) begin
        head_q      <= head_d;
        bump_q      <= bump_d;
        total_q     <= total_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== hdl/generational_slot_allocator_top.sv =====
// ----------------------------------------------------------------------------
// generational_slot_allocator_top
// Pool of slots handed out as handles (one-based index, generation).
// ----------------------------------------------------------------------------
// Each request passes through two back-end states: ST_READ reads the slot's
// memory word (active mark, generation, free-list link) through the single
// read port, and ST_EXEC evaluates it, writes it back and updates the
// free-list head. No new request is taken until ST_EXEC is done with the
// last one, and ST_EXEC waits while a result is untaken. A two-entry queue
// behind the input keeps taking requests while the back end works, and the
// result register holds a finished result until it is taken. No clearing
// pass follows reset: a fill mark stands in for the reset contents of
// never-used slots, so the block takes requests as soon as reset is released.
module generational_slot_allocator_top #(
  parameter int unsigned SLOTS    = gsa_pkg::SlotsDef,
  parameter int unsigned GEN_BITS = gsa_pkg::GenBitsDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  gsa_pkg::req_t in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output gsa_pkg::rsp_t out_data_o
);
  import gsa_pkg::*;

  logic q_valid;
  logic q_pop;
  cls_t q_item;

  gsa_front #(
    .SLOTS(SLOTS)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .in_data_i (in_data_i),
    .q_valid_o (q_valid),
    .q_pop_i   (q_pop),
    .q_item_o  (q_item)
  );

  gsa_back #(
    .SLOTS   (SLOTS),
    .GEN_BITS(GEN_BITS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_valid_i  (q_valid),
    .q_pop_o    (q_pop),
    .q_item_i   (q_item),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

endmodule

// ===== hdl/gsa_checker.sv =====
// ----------------------------------------------------------------------------
// gsa_checker
// Port-level checks of the slot allocator, bound to the top level.
// ----------------------------------------------------------------------------
module gsa_checker #(
  parameter int unsigned SLOTS = gsa_pkg::SlotsDef
) (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          out_valid_o,
  input logic          out_ready_i,
  input gsa_pkg::rsp_t out_data_o
);
  import gsa_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");

  a_live_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.live_count <= LiveW'(SLOTS))
    else $error("live count above pool size");

  a_index_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.out_index != '0) |->
      out_data_o.ok && (out_data_o.out_index <= OIdxW'(SLOTS)) &&
      (out_data_o.live_count != '0))
    else $error("allocated index without success or out of range");

  a_gen_only_alloc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.out_generation != '0) |-> out_data_o.out_index != '0)
    else $error("generation reported without allocation");

endmodule

bind generational_slot_allocator_top gsa_checker #(
  .SLOTS(SLOTS)
) u_gsa_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .out_valid_o(out_valid_o),
  .out_ready_i(out_ready_i),
  .out_data_o (out_data_o)
);

// ===== tb/alloc_tb_pkg.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// alloc_tb_pkg
// Scoreboard for the generational slot allocator: a cycle-free model of the
// slot pool that predicts one response per accepted request and compares
// each delivered response against the oldest prediction.
// ----------------------------------------------------------------------------
package alloc_tb_pkg;

  import gsa_pkg::*;

  localparam int unsigned PoolSlots = gsa_pkg::SlotsDef;

  class slot_pool_model;

    logic [10:0] next_link [PoolSlots];
    logic        is_active [PoolSlots];
    logic [7:0]  slot_gen  [PoolSlots];
    logic [10:0] head;
    logic [10:0] active_cnt;

    rsp_t        expected_rsp_q[$];
    int unsigned mismatches;

    logic        last_ok;
    logic [11:0] last_idx;
    logic [7:0]  last_gen;

    function new();
      for (int unsigned i = 0; i < PoolSlots; i++) begin
        next_link[i] = 11'(i + 1);
        is_active[i] = 1'b0;
        slot_gen[i]  = '0;
      end
      head       = '0;
      active_cnt = '0;
      mismatches = 0;
      last_ok    = 1'b0;
      last_idx   = '0;
      last_gen   = '0;
    endfunction

    function bit handle_live(logic [11:0] idx, logic [7:0] g);
      if (idx == 0 || idx > PoolSlots) return 1'b0;
      return is_active[idx-1] && (slot_gen[idx-1] == g);
    endfunction

    function logic [7:0] gen_of(logic [11:0] idx);
      if (idx == 0 || idx > PoolSlots) return '0;
      return slot_gen[idx-1];
    endfunction

    function bit pool_empty();
      return head >= PoolSlots;
    endfunction

    function int unsigned pending();
      return expected_rsp_q.size();
    endfunction

    // Pick a random live handle; returns 0 when no slot is active.
    function bit pick_live(output logic [11:0] idx, output logic [7:0] g);
      int unsigned start;
      int unsigned s;
      idx = '0;
      g   = '0;
      if (active_cnt == 0) return 1'b0;
      start = $urandom_range(0, PoolSlots - 1);
      for (int unsigned k = 0; k < PoolSlots; k++) begin
        s = (start + k) % PoolSlots;
        if (is_active[s]) begin
          idx = 12'(s + 1);
          g   = slot_gen[s];
          return 1'b1;
        end
      end
      return 1'b0;
    endfunction

    function void note_request(req_t r);
      rsp_t        want;
      int unsigned s;
      want = '0;
      case (r.mode)
        OP_ALLOC: begin
          last_ok = 1'b0;
          if (head < PoolSlots) begin
            s    = head;
            head = next_link[s];
            if (head > PoolSlots) head = 11'(PoolSlots);
            is_active[s] = 1'b1;
            active_cnt   = active_cnt + 1'b1;
            want.ok             = 1'b1;
            want.out_index      = 11'(s + 1);
            want.out_generation = slot_gen[s];
            last_ok  = 1'b1;
            last_idx = 12'(s + 1);
            last_gen = slot_gen[s];
          end
        end
        OP_FREE: begin
          if (handle_live(r.handle_index, r.handle_generation)) begin
            s = r.handle_index - 1;
            is_active[s] = 1'b0;
            slot_gen[s]  = slot_gen[s] + 1'b1;
            next_link[s] = head;
            head         = 11'(s);
            if (active_cnt > 0) active_cnt = active_cnt - 1'b1;
            want.ok = 1'b1;
          end
        end
        OP_CHECK: want.ok = handle_live(r.handle_index, r.handle_generation);
        default: ;
      endcase
      want.live_count = active_cnt;
      expected_rsp_q.push_back(want);
    endfunction

    function void compare_field(string name, logic [11:0] want, logic [11:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
        mismatches++;
      end
    endfunction

    function void check_result(rsp_t got);
      rsp_t want;
      if (expected_rsp_q.size() == 0) begin
        $display("%0t: response with no request pending: expected none, actual %h",
                 $time, got);
        mismatches++;
        return;
      end
      want = expected_rsp_q.pop_front();
      compare_field("ok", 12'(want.ok), 12'(got.ok));
      compare_field("out_index", 12'(want.out_index), 12'(got.out_index));
      compare_field("out_generation", 12'(want.out_generation), 12'(got.out_generation));
      compare_field("live_count", 12'(want.live_count), 12'(got.live_count));
    endfunction

  endclass

endpackage

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Testbench of the generational slot allocator. Drives directed and random
// allocate, free, check and no-op requests over valid/ready with random
// idling on both sides, wraps a slot generation, frees live handles in bulk,
// and checks every response against the scoreboard's prediction.
// ----------------------------------------------------------------------------
module tb_top;

  import gsa_pkg::*;
  import alloc_tb_pkg::*;

  localparam int unsigned WATCHDOG_CYCLES = 3000;
  localparam int unsigned HOLD_CYCLES     = 400;

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_ready_o;
  req_t in_data_i;
  logic out_valid_o;
  logic out_ready_i;
  rsp_t out_data_o;

  bit no_idle;
  bit rx_hold;

  slot_pool_model sb = new();

  generational_slot_allocator_top u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic int unsigned idle_len();
    int unsigned p;
    if (no_idle) return 0;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 85) return $urandom_range(1, 3);
    if (p < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic req_t mk(op_e op, logic [11:0] idx, logic [7:0] g);
    req_t r;
    r.mode              = op;
    r.handle_index      = idx;
    r.handle_generation = g;
    return r;
  endfunction

  function automatic req_t random_req();
    req_t        r;
    logic [11:0] idx;
    logic [7:0]  g;
    int unsigned p;
    r = mk(OP_ALLOC, 12'($urandom), 8'($urandom));
    p = $urandom_range(0, 99);
    if (p < 35) begin
      r.mode = OP_ALLOC;
    end else if (p < 78) begin
      if (sb.pick_live(idx, g)) begin
        r.handle_index      = idx;
        r.handle_generation = g;
        if (p >= 70) r.handle_generation = g + 8'($urandom_range(1, 255));
      end
      if (p < 55) r.mode = OP_FREE;
      else if (p < 70) r.mode = OP_CHECK;
      else r.mode = $urandom_range(0, 1) ? OP_FREE : OP_CHECK;
    end else if (p < 84) begin
      r.mode = $urandom_range(0, 1) ? OP_FREE : OP_CHECK;
      r.handle_index = ($urandom_range(0, 3) == 0) ? 12'd0 :
                       12'($urandom_range(PoolSlots + 1, 4095));
    end else if (p < 90) begin
      r.mode = $urandom_range(0, 1) ? OP_FREE : OP_CHECK;
      r.handle_index      = 12'($urandom_range(1, PoolSlots));
      r.handle_generation = sb.gen_of(r.handle_index);
    end else begin
      r.mode              = 2'($urandom_range(0, 3));
      r.handle_index      = 12'($urandom_range(0, 4095));
      r.handle_generation = 8'($urandom_range(0, 255));
    end
    return r;
  endfunction

  function automatic req_t pick_free();
    logic [11:0] idx;
    logic [7:0]  g;
    if (sb.pick_live(idx, g)) return mk(OP_FREE, idx, g);
    return random_req();
  endfunction

  // Offer one request, hold it until the transfer, then idle for a random spell, which may be none.
  task automatic send_req(input req_t r);
    int unsigned g;
    in_valid_i <= 1'b1;
    in_data_i  <= r;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_request(r);
    g = idle_len();
    if (g > 0) begin
      in_valid_i <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  task automatic send_random(input int unsigned n);
    repeat (n) send_req(random_req());
  endtask

  initial begin
    in_valid_i <= 1'b0;
    in_data_i  <= '0;
    rst_ni     <= 1'b0;
    no_idle    = 1'b0;
    rx_hold    = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_req(mk(OP_CHECK, 12'd1, 8'd0));
    send_req(mk(OP_FREE, 12'd1, 8'd0));
    send_req(mk(OP_ALLOC, '1, '1));
    send_req(mk(OP_ALLOC, '0, '0));
    send_req(mk(OP_CHECK, 12'd1, 8'd0));
    send_req(mk(OP_CHECK, 12'd1, 8'd255));
    send_req(mk(OP_CHECK, 12'd0, 8'd0));
    send_req(mk(OP_FREE, 12'd0, 8'd0));
    send_req(mk(OP_FREE, 12'd4095, 8'd255));
    send_req(mk(OP_CHECK, 12'(PoolSlots + 1), 8'd0));
    send_req(mk(OP_CHECK, 12'(PoolSlots), 8'd0));
    send_req(mk(OP_NOP, '1, '1));
    send_req(mk(OP_NOP, '0, '0));
    send_req(mk(OP_FREE, 12'd1, 8'd0));
    send_req(mk(OP_FREE, 12'd1, 8'd0));
    send_req(mk(OP_CHECK, 12'd1, 8'd0));
    send_req(mk(OP_CHECK, 12'd1, 8'd1));
    send_req(mk(OP_ALLOC, '0, '1));
    send_req(mk(OP_FREE, 12'd2, 8'd0));
    send_req(mk(OP_FREE, 12'd1, 8'd1));
    send_req(mk(OP_ALLOC, '1, '0));
    send_req(mk(OP_FREE, 12'd1, 8'd2));

    send_random(250);

    no_idle = 1'b1;
    send_random(80);
    no_idle = 1'b0;

    rx_hold = 1'b1;
    while (rx_hold) send_req(random_req());
    wait_drained();

    // Cycle one slot through alloc/free until its generation wraps.
    repeat (258) begin
      send_req(mk(OP_ALLOC, 12'($urandom), 8'($urandom)));
      if (sb.last_ok) begin
        if ($urandom_range(0, 7) == 0) send_req(mk(OP_CHECK, sb.last_idx, sb.last_gen));
        send_req(mk(OP_FREE, sb.last_idx, sb.last_gen));
      end
    end

    wait_drained();
    repeat (30) send_req(pick_free());
    send_random(20);

    wait_drained();
    repeat (20) @(posedge clk_i);
    if (sb.mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    out_ready_i <= 1'b0;
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (rx_hold) begin
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        rx_hold = 1'b0;
      end else begin
        int unsigned g;
        g = idle_len();
        if (g > 0) begin
          out_ready_i <= 1'b0;
          repeat (g) @(posedge clk_i);
        end
      end
      out_ready_i <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) sb.check_result(out_data_o);
  end

  initial begin
    int unsigned quiet;
    quiet = 0;
    forever begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet = 0;
      else quiet++;
      if (quiet >= WATCHDOG_CYCLES) begin
        $display("%0t: no transfer for %0d cycles", $time, quiet);
        $display("Mismatches found");
        $finish;
      end
    end
  end

endmodule
